FILE: rtl/core/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types of the 3x3 sobel edge magnitude filter.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned MaxWidth   = 512;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned MinDim     = 3;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned WidthRegW  = 10;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(512);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(512);

  // register index, taken from paddr[2]
  typedef enum logic {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } reg_idx_e;

  typedef logic [PixW-1:0] pix_t;

  // window as it leaves the front, centre pixel dropped (weight zero in both kernels)
  typedef struct packed {
    pix_t            p00;
    pix_t            p01;
    pix_t            p02;
    pix_t            p10;
    pix_t            p12;
    pix_t            p20;
    pix_t            p21;
    pix_t            p22;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic nearly_full;
    logic not_empty;
  } q_stat_t;

endpackage

FILE: rtl/core/sobel_ram.sv
// ----------------------------------------------------------------------------
// sobel_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old value on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sobel_front.sv
// ----------------------------------------------------------------------------
// sobel_front
// Accepts pixels, tracks raster position, keeps two line stores and the 3x3
// window, and pushes every window that has a valid centre into the queue.
// ----------------------------------------------------------------------------
module sobel_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sobel_pkg::WidthRegW-1:0]    image_width_i,
  input  logic [sobel_pkg::HeightRegW-1:0]   image_height_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sobel_pkg::PixW-1:0]         pixel_i,
  input  sobel_pkg::q_stat_t                 q_stat_i,
  output logic                               push_o,
  output sobel_pkg::q_entry_t                push_data_o
);

  import sobel_pkg::*;

  logic [ColW-1:0]       col_q;
  logic [RowW-1:0]       row_q;
  logic [WidthRegW-1:0]  w_eff;
  logic [HeightRegW-1:0] h_eff;
  logic                  col_end;
  logic                  row_end;
  logic                  accept;

  logic                  s1_valid_q;
  logic [ColW-1:0]       s1_addr_q;
  pix_t                  s1_pix_q;
  logic                  s1_emit_q;
  logic [RowW-1:0]       s1_row_q;
  logic [ColW-1:0]       s1_col_q;
  logic                  s1_last_q;

  pix_t                  top;
  pix_t                  mid;
  pix_t                  win_q [9];
  pix_t                  win_d [9];

  always_comb begin
    priority if (image_width_i < WidthRegW'(MinDim)) begin
      w_eff = WidthRegW'(MinDim);
    end else if (image_width_i > WidthRegW'(MaxWidth)) begin
      w_eff = WidthRegW'(MaxWidth);
    end else begin
      w_eff = image_width_i;
    end
  end

  always_comb begin
    priority if (image_height_i < HeightRegW'(MinDim)) begin
      h_eff = HeightRegW'(MinDim);
    end else if (image_height_i > HeightRegW'(MaxHeight)) begin
      h_eff = HeightRegW'(MaxHeight);
    end else begin
      h_eff = image_height_i;
    end
  end

  assign col_end = (WidthRegW'(col_q) + WidthRegW'(1)) >= w_eff;
  assign row_end = (HeightRegW'(row_q) + HeightRegW'(1)) >= h_eff;

  // reserve a queue slot for the item sitting in the second stage
  assign in_stall_o = q_stat_i.full || (q_stat_i.nearly_full && s1_valid_q);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : row_q + RowW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= pixel_i;
      s1_emit_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_row_q  <= row_q - RowW'(1);
      s1_col_q  <= col_q - ColW'(1);
      s1_last_q <= row_end && col_end;
    end
  end

  // row one up: read and rewritten with the new pixel on accept
  sobel_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (pixel_i),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid)
  );

  // row two up: takes the old row-one-up value in the following cycle
  sobel_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (mid),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3+0] = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = top;
    win_d[5] = mid;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  assign push_o = s1_valid_q && s1_emit_q;

  always_comb begin
    push_data_o.p00  = win_d[0];
    push_data_o.p01  = win_d[1];
    push_data_o.p02  = win_d[2];
    push_data_o.p10  = win_d[3];
    push_data_o.p12  = win_d[5];
    push_data_o.p20  = win_d[6];
    push_data_o.p21  = win_d[7];
    push_data_o.p22  = win_d[8];
    push_data_o.row  = s1_row_q;
    push_data_o.col  = s1_col_q;
    push_data_o.last = s1_last_q;
  end

endmodule

FILE: rtl/core/sobel_fifo.sv
// ----------------------------------------------------------------------------
// sobel_fifo
// Short queue of windows between the front and the gradient back end.
// ----------------------------------------------------------------------------
module sobel_fifo #(
  parameter int unsigned Depth = sobel_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sobel_pkg::q_entry_t push_data_i,
  input  logic                pop_i,
  output sobel_pkg::q_entry_t pop_data_o,
  output sobel_pkg::q_stat_t  q_stat_o
);

  import sobel_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t        slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign do_push = push_i && (count_q != CntW'(Depth));
  assign do_pop  = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o           = slot_q[rd_ptr_q];
  assign q_stat_o.full        = (count_q == CntW'(Depth));
  assign q_stat_o.nearly_full = (count_q >= CntW'(Depth - 1));
  assign q_stat_o.not_empty   = (count_q != '0);

endmodule

FILE: rtl/core/sobel_back.sv
// ----------------------------------------------------------------------------
// sobel_back
// Pops windows, forms |gx|+|gy| saturated to 8 bits, and holds the result in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sobel_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sobel_pkg::q_stat_t           q_stat_i,
  output logic                         pop_o,
  input  sobel_pkg::q_entry_t          pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sobel_pkg::PixW-1:0]   magnitude_o,
  output logic [sobel_pkg::RowW-1:0]   centre_row_o,
  output logic [sobel_pkg::ColW-1:0]   centre_col_o,
  output logic                         frame_last_o
);

  import sobel_pkg::*;

  localparam int unsigned SumW = PixW + 2;

  q_entry_t         e;
  logic [SumW-1:0]  gx_pos;
  logic [SumW-1:0]  gx_neg;
  logic [SumW-1:0]  gy_pos;
  logic [SumW-1:0]  gy_neg;
  logic [SumW-1:0]  gx_abs;
  logic [SumW-1:0]  gy_abs;
  logic [SumW:0]    mag_sum;
  pix_t             mag_sat;

  logic             out_valid_q;
  pix_t             magnitude_q;
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic             last_q;

  assign e = pop_data_i;

  // weight-2 taps enter as a one-bit left shift
  assign gx_pos = SumW'(e.p02) + SumW'({e.p12, 1'b0}) + SumW'(e.p22);
  assign gx_neg = SumW'(e.p00) + SumW'({e.p10, 1'b0}) + SumW'(e.p20);
  assign gy_pos = SumW'(e.p00) + SumW'({e.p01, 1'b0}) + SumW'(e.p02);
  assign gy_neg = SumW'(e.p20) + SumW'({e.p21, 1'b0}) + SumW'(e.p22);

  assign gx_abs  = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
  assign gy_abs  = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
  assign mag_sum = (SumW+1)'(gx_abs) + (SumW+1)'(gy_abs);
  assign mag_sat = (mag_sum > (SumW+1)'(255)) ? PixW'(255) : mag_sum[PixW-1:0];

  assign pop_o = q_stat_i.not_empty && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= q_stat_i.not_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      magnitude_q <= mag_sat;
      row_q       <= e.row;
      col_q       <= e.col;
      last_q      <= e.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign magnitude_o  = magnitude_q;
  assign centre_row_o = row_q;
  assign centre_col_o = col_q;
  assign frame_last_o = last_q;

endmodule

FILE: rtl/core/sobel_edge_magnitude_filter_top.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_filter_top
// 3x3 sobel edge magnitude over a raster pixel stream, |gx|+|gy| clipped
// to 255, with an apb register port for the frame size.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid_i/pixel_i; an item is taken at a
//   clock edge with in_valid_i high and in_stall_o low. One pixel per cycle is
//   taken as long as results drain.
//   Every pixel at row 2 or later and column 2 or later yields one result for
//   the centre one row up and one column left; border pixels yield nothing.
//   A result shows on out_valid_o once its pixel has passed the line store
//   read register and the window queue into the output register.
//   frame_last_o marks the result caused by the frame's final pixel.
//   When the receiver holds out_stall_i the result stays on the outputs, the
//   four-entry queue fills, and in_stall_o rises once no slot is left for the
//   pixel already past the line store read.
//   image_width (addr 0x0) and image_height (addr 0x4) must be written only
//   while the block is idle, which it does not enforce; values outside 3..512
//   and 3..4096 are clipped. Reset sets both to 512, clears the row and column
//   position and the window; line stores are not cleared and need no clearing.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_filter_top #(
  parameter int unsigned QueueDepth = sobel_pkg::QueueDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sobel_pkg::ApbAddrW-1:0]   paddr,
  input  logic [sobel_pkg::ApbDataW-1:0]   pwdata,
  output logic [sobel_pkg::ApbDataW-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sobel_pkg::PixW-1:0]       pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sobel_pkg::PixW-1:0]       magnitude_o,
  output logic [sobel_pkg::RowW-1:0]       centre_row_o,
  output logic [sobel_pkg::ColW-1:0]       centre_col_o,
  output logic                             frame_last_o
);

  import sobel_pkg::*;

  logic [WidthRegW-1:0]  image_width_q;
  logic [HeightRegW-1:0] image_height_q;
  reg_idx_e              reg_sel;
  logic                  cfg_write;

  logic                  push;
  q_entry_t              push_data;
  logic                  pop;
  q_entry_t              pop_data;
  q_stat_t               q_stat;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        RegImageWidth:  image_width_q  <= pwdata[WidthRegW-1:0];
        RegImageHeight: image_height_q <= pwdata[HeightRegW-1:0];
        default:        image_width_q  <= image_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegImageWidth:  prdata = ApbDataW'(image_width_q);
      RegImageHeight: prdata = ApbDataW'(image_height_q);
      default:        prdata = '0;
    endcase
  end

  sobel_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  sobel_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  sobel_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .magnitude_o  (magnitude_o),
    .centre_row_o (centre_row_o),
    .centre_col_o (centre_col_o),
    .frame_last_o (frame_last_o)
  );

  // the front's slot reservation must keep the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("window pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_stat.not_empty)
    else $error("window popped from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !q_stat.full)
    else $error("pixel taken with no queue slot left");

  // border centres never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (centre_row_o != '0) && (centre_col_o != '0))
    else $error("result on a border centre");

endmodule

FILE: test/tb_sobel_edge_magnitude_filter_top.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_filter_top
// Streams pixel frames of several sizes through the sobel filter with random
// idle cycles on both channels and checks every result, in order, against an
// in-bench model of the line stores, the 3x3 window and the frame position.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sobel_pkg::*;

  localparam int unsigned RandomItems    = 100;
  localparam int unsigned SqueezeCycles  = 300;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned StallLimit     = 5000;

  typedef struct packed {
    pix_t            magnitude;
    logic [RowW-1:0] centre_row;
    logic [ColW-1:0] centre_col;
    logic            frame_last;
  } edge_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  pix_t            pixel_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  pix_t            magnitude_o;
  logic [RowW-1:0] centre_row_o;
  logic [ColW-1:0] centre_col_o;
  logic            frame_last_o;

  sobel_edge_magnitude_filter_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .magnitude_o (magnitude_o),
    .centre_row_o(centre_row_o),
    .centre_col_o(centre_col_o),
    .frame_last_o(frame_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // filter model state
  pix_t                  upper_line[MaxWidth];
  pix_t                  lower_line[MaxWidth];
  pix_t                  win[3][3] = '{default: '0};
  int unsigned           col_pos = 0;
  int unsigned           row_pos = 0;
  logic [WidthRegW-1:0]  width_reg = WidthReset;
  logic [HeightRegW-1:0] height_reg = HeightReset;

  edge_result_t expected_edges[$];
  pix_t         pixel_queue[$];
  bit           pixel_busy = 1'b0;
  int unsigned  fault_count = 0;

  // pacing controls of the sender and the receiver
  bit          quiet_mode = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  // stimulus bookkeeping
  bit          tally = 1'b0;
  int unsigned random_items = 0;
  int unsigned pixel_style = 0;
  int          smooth_level = 128;

  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v < MinDim) return MinDim;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    if (quiet_mode || hold_left != 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic predict_pixel(input pix_t px);
    int unsigned  w, h, c;
    pix_t         above2, above1;
    int           v[3][3];
    int           gx, gy, mag;
    edge_result_t res;
    w = clip_dim(width_reg, MaxWidth);
    h = clip_dim(height_reg, MaxHeight);
    c = col_pos % MaxWidth;
    above2 = upper_line[c];
    above1 = lower_line[c];
    upper_line[c] = above1;
    lower_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          v[i][j] = int'(win[i][j]);
        end
      end
      gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
      gy = (v[0][0] + 2 * v[0][1] + v[0][2]) - (v[2][0] + 2 * v[2][1] + v[2][2]);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      mag = gx + gy;
      if (mag > 255) mag = 255;
      res.magnitude  = pix_t'(mag);
      res.centre_row = RowW'(row_pos - 1);
      res.centre_col = ColW'(col_pos - 1);
      res.frame_last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      expected_edges.push_back(res);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) row_pos = 0;
      else row_pos = (row_pos + 1) & 32'hFFF;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // sender: valid holds while stalled, gaps only between items
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_pixel(pixel_i);
        pixel_busy = 1'b0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          pixel_i <= pixel_queue.pop_front();
          pixel_busy = 1'b1;
          send_gap = pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and paces out_stall_i
  always @(posedge clk_i) begin : recv_side
    edge_result_t want;
    int unsigned  n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_edges.size() == 0) begin
          $error("result with nothing expected: row %0d col %0d mag %0d",
                 centre_row_o, centre_col_o, magnitude_o);
          fault_count++;
        end else begin
          want = expected_edges.pop_front();
          if (magnitude_o !== want.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want.magnitude, magnitude_o);
            fault_count++;
          end
          if (centre_row_o !== want.centre_row) begin
            $error("centre_row: expected %0d, got %0d", want.centre_row, centre_row_o);
            fault_count++;
          end
          if (centre_col_o !== want.centre_col) begin
            $error("centre_col: expected %0d, got %0d", want.centre_col, centre_col_o);
            fault_count++;
          end
          if (frame_last_o !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, frame_last_o);
            fault_count++;
          end
        end
        // long hold-off once results flow, so the queue fills and the input stalls
        if (squeeze_req && !squeeze_done) begin
          hold_left = SqueezeCycles;
          squeeze_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        n = pick_pause();
        out_stall_i <= (n != 0);
        stall_left = (n != 0) ? n - 1 : 0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(int'(idx) * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegImageWidth) width_reg = val[WidthRegW-1:0];
    else if (idx == RegImageHeight) height_reg = val[HeightRegW-1:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || pixel_busy || expected_edges.size() != 0);
    // a pixel that yields no result may still be in the pipe
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_pixels(input int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      case (pixel_style)
        0: r = $urandom_range(0, 255);
        1: r = $urandom_range(0, 1) ? 255 : 0;
        default: begin
          smooth_level += int'($urandom_range(0, 24)) - 12;
          if (smooth_level < 0) smooth_level = 0;
          if (smooth_level > 255) smooth_level = 255;
          r = smooth_level;
        end
      endcase
      pixel_queue.push_back(pix_t'(r));
    end
    if (tally) random_items += n;
  endtask

  // feed what is left of the current frame so the position returns to the origin
  task automatic finish_frame();
    int unsigned w, h, left;
    wait_idle();
    if (col_pos == 0 && row_pos == 0) return;
    w = clip_dim(width_reg, MaxWidth);
    h = clip_dim(height_reg, MaxHeight);
    left = (col_pos + 1 >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) left += (h - row_pos - 1) * w;
    queue_pixels(left);
    wait_idle();
  endtask

  task automatic pick_frame_size();
    int unsigned r, wv, hv;
    r = $urandom_range(0, 99);
    if (r < 70) wv = $urandom_range(3, 12);
    else if (r < 82) wv = $urandom_range(13, 64);
    else if (r < 88) wv = $urandom_range(0, 2);
    else if (r < 94) wv = $urandom_range(65, 512);
    else wv = $urandom_range(513, 1023);
    r = $urandom_range(0, 99);
    if (r < 75) hv = $urandom_range(3, 8);
    else if (r < 85) hv = $urandom_range(9, 40);
    else if (r < 92) hv = $urandom_range(0, 2);
    else hv = $urandom_range(41, 8191);
    reg_write(RegImageWidth, wv);
    reg_write(RegImageHeight, hv);
  endtask

  initial begin : stimulus
    int unsigned ew, eh, n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest frame: flat field, hard vertical edge, gentle ramp
    reg_write(RegImageWidth, 3);
    reg_write(RegImageHeight, 3);
    repeat (9) pixel_queue.push_back(8'd255);
    for (int i = 0; i < 9; i++) pixel_queue.push_back((i % 3 == 0) ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(pix_t'(i + 1));
    wait_idle();

    // below-minimum sizes clip to 3x3
    reg_write(RegImageWidth, 0);
    reg_write(RegImageHeight, 2);
    queue_pixels(9);
    wait_idle();

    // widest frame via an oversized value, with a long receiver hold-off
    reg_write(RegImageWidth, 1023);
    reg_write(RegImageHeight, 3);
    squeeze_req = 1'b1;
    queue_pixels(MaxWidth * 3);
    wait_idle();

    // tallest frame, then shrink the height while past the new end
    reg_write(RegImageWidth, 3);
    reg_write(RegImageHeight, MaxHeight);
    queue_pixels(33);
    wait_idle();
    reg_write(RegImageHeight, 5);
    finish_frame();

    // exact maximum width and oversized height, then shrink both mid-frame
    reg_write(RegImageWidth, MaxWidth);
    reg_write(RegImageHeight, 8191);
    queue_pixels(8);
    wait_idle();
    reg_write(RegImageWidth, 5);
    reg_write(RegImageHeight, 4);
    finish_frame();

    tally = 1'b1;
    while (random_items < RandomItems) begin
      quiet_mode = ($urandom_range(0, 5) == 0);
      pixel_style = $urandom_range(0, 2);
      pick_frame_size();
      ew = clip_dim(width_reg, MaxWidth);
      eh = clip_dim(height_reg, MaxHeight);
      if (ew * eh > 300 || $urandom_range(0, 3) == 0) begin
        // partial frame, then a smaller size that can leave the position past the end
        n = ew * eh - 1;
        if (n > 200) n = 200;
        queue_pixels($urandom_range(1, n));
        wait_idle();
        n = (ew < 16) ? ew : 16;
        reg_write(RegImageWidth, $urandom_range(MinDim, n));
        reg_write(RegImageHeight, $urandom_range(MinDim, 8));
      end
      if ($urandom_range(0, 2) == 0 && col_pos == 0 && row_pos == 0) begin
        ew = clip_dim(width_reg, MaxWidth);
        eh = clip_dim(height_reg, MaxHeight);
        queue_pixels(ew * eh);
      end
      finish_frame();
    end
    quiet_mode = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (expected_edges.size() != 0) begin
      $error("%0d results never arrived", expected_edges.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sobel_pkg.sv
rtl/core/sobel_ram.sv
rtl/core/sobel_front.sv
rtl/core/sobel_fifo.sv
rtl/core/sobel_back.sv
rtl/core/sobel_edge_magnitude_filter_top.sv
test/tb_sobel_edge_magnitude_filter_top.sv
